// ===== design/urf_pkg.sv =====
// Shared types, opcodes, register offsets and control and status bit positions for the UART register block.
package urf_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 16;
   localparam int SPACE_WIDTH = 5;

   // Request operation codes.
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_RX    = 2'd2;

   // Register byte offsets.
   localparam logic [7:0] ADDR_DATA    = 8'h00;
   localparam logic [7:0] ADDR_STATUS  = 8'h04;
   localparam logic [7:0] ADDR_CONTROL = 8'h08;

   // Control register bits.
   localparam int CT_TX_EN     = 0;
   localparam int CT_RX_EN     = 1;
   localparam int CT_TX_INT_EN = 2;
   localparam int CT_RX_INT_EN = 3;

   // Status register bits.
   localparam int ST_TX_READY = 0;
   localparam int ST_RX_AVAIL = 1;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   typedef struct packed {
      logic [31:0]            read_data;
      logic                   tx_valid;
      logic [7:0]             tx_byte;
      logic                   irq_level;
      logic                   rx_stored;
      logic [SPACE_WIDTH-1:0] rx_space;
      logic                   bus_error;
   } rsp_type;

endpackage

// ===== design/urf_if.sv =====
// Request and response channel interfaces of the UART register block.
interface urf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [7:0]  address;
   logic [31:0] write_data;
   logic [7:0]  rx_byte;

   modport source (output valid, output operation, output address, output write_data,
                   output rx_byte, input ready);
   modport sink (input valid, input operation, input address, input write_data,
                 input rx_byte, output ready);
endinterface

interface urf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [31:0]                    read_data;
   logic                           tx_valid;
   logic [7:0]                     tx_byte;
   logic                           irq_level;
   logic                           rx_stored;
   logic [urf_pkg::SPACE_WIDTH-1:0] rx_space;
   logic                           bus_error;

   modport source (output valid, output read_data, output tx_valid, output tx_byte,
                   output irq_level, output rx_stored, output rx_space, output bus_error,
                   input ready);
   modport sink (input valid, input read_data, input tx_valid, input tx_byte,
                 input irq_level, input rx_stored, input rx_space, input bus_error,
                 output ready);
endinterface

// ===== design/urf_cell.sv =====
// One byte cell of the receive FIFO shift chain.
module urf_cell (
   input  logic       clock,
   input  logic       shift,
   input  logic       load,
   input  logic [7:0] shift_data,
   input  logic [7:0] load_data,
   output logic [7:0] data
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // A pop moves every byte one cell towards the head; a push fills the first free cell.
   always_comb begin
      data_in = data_ff;
      if (shift) begin
         data_in = shift_data;
      end else if (load) begin
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== design/urf_fifo.sv =====
// Receive FIFO built as a chain of byte cells with a fill counter.
module urf_fifo #(
   parameter int FIFO_DEPTH = urf_pkg::FIFO_DEPTH_DEFAULT,
   parameter int FILL_WIDTH = $clog2(FIFO_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  urf_pkg::fifo_ctrl_type ctrl,
   input  logic [7:0]            push_data,
   output logic [7:0]            head_data,
   output logic [FILL_WIDTH-1:0] fill
);

   logic [FILL_WIDTH-1:0] fill_ff;
   logic [FILL_WIDTH-1:0] fill_in;
   logic [7:0]            cell_data [FIFO_DEPTH];

   for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
      logic [7:0] next_data;
      if (i == FIFO_DEPTH - 1) begin : g_last
         assign next_data = 8'h00;
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end
      urf_cell u_cell (
         .clock      (clock),
         .shift      (ctrl.pop),
         .load       (ctrl.push && (fill_ff == FILL_WIDTH'(i))),
         .shift_data (next_data),
         .load_data  (push_data),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctrl.push && !ctrl.pop) begin
         fill_in = fill_ff + FILL_WIDTH'(1);
      end else if (ctrl.pop && !ctrl.push) begin
         fill_in = fill_ff - FILL_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign head_data = cell_data[0];
   assign fill      = fill_ff;

endmodule

// ===== design/uart_registers_rx_fifo.sv =====
// Top level of the UART register block with its receive FIFO and response buffer.
//
//   channel   direction  handshake       payload
//   req_port  in         valid / ready   operation, address, write_data, rx_byte
//   rsp_port  out        valid / ready   read_data, tx_valid, tx_byte, irq_level,
//                                        rx_stored, rx_space, bus_error
//
// Each request's effect on the registers and the FIFO cell chain is applied at
// acceptance, and its response is registered in the response buffer for rsp_port.
// A two-entry response buffer keeps requests flowing at one per cycle; req_port.ready
// drops only when both entries are held by a stalled response side.
// Reset is synchronous; it empties the FIFO, clears control and the interrupt and sets
// TX ready. FIFO cell contents are not reset.
module uart_registers_rx_fifo #(
   parameter int FIFO_DEPTH = urf_pkg::FIFO_DEPTH_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   urf_req_if.sink   req_port,
   urf_rsp_if.source rsp_port
);

   localparam int FILL_WIDTH = $clog2(FIFO_DEPTH + 1);

   logic [31:0] control_ff, control_in;
   logic        tx_ready_ff, tx_ready_in;
   logic        rx_avail_ff, rx_avail_in;
   logic        irq_ff, irq_in;
   logic [1:0]  count_ff, count_in;
   urf_pkg::rsp_type slot0_ff, slot1_ff;
   urf_pkg::rsp_type result;
   urf_pkg::fifo_ctrl_type fifo_ctrl;

   logic [7:0]            head_data;
   logic [FILL_WIDTH-1:0] fill;
   logic [FILL_WIDTH-1:0] fill_after;
   logic [FILL_WIDTH-1:0] free_entries;
   logic                  accept;
   logic                  rsp_take;
   logic                  push_hit;
   logic                  pop_hit;

   assign req_port.ready = (count_ff != 2'd2);
   assign accept         = req_port.valid && req_port.ready;
   assign rsp_take       = (count_ff != 2'd0) && rsp_port.ready;

   urf_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .FILL_WIDTH (FILL_WIDTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fifo_ctrl),
      .push_data (req_port.rx_byte),
      .head_data (head_data),
      .fill      (fill)
   );

   always_comb begin
      control_in       = control_ff;
      tx_ready_in      = tx_ready_ff;
      rx_avail_in      = rx_avail_ff;
      irq_in           = irq_ff;
      push_hit         = 1'b0;
      pop_hit          = 1'b0;
      result           = '0;
      case (req_port.operation)
         urf_pkg::OP_READ: begin
            case (req_port.address)
               urf_pkg::ADDR_DATA: begin
                  if (fill != '0) begin
                     pop_hit          = 1'b1;
                     result.read_data = {24'h000000, head_data};
                     if (fill == FILL_WIDTH'(1)) begin
                        rx_avail_in = 1'b0;
                     end
                  end
               end
               urf_pkg::ADDR_STATUS: begin
                  result.read_data[urf_pkg::ST_TX_READY] = tx_ready_ff;
                  result.read_data[urf_pkg::ST_RX_AVAIL] = rx_avail_ff;
               end
               urf_pkg::ADDR_CONTROL: begin
                  result.read_data = control_ff;
               end
               default: begin
                  result.bus_error = 1'b1;
               end
            endcase
         end
         urf_pkg::OP_WRITE: begin
            case (req_port.address)
               urf_pkg::ADDR_DATA: begin
                  if (control_ff[urf_pkg::CT_TX_EN]) begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = req_port.write_data[7:0];
                     tx_ready_in     = 1'b1;
                     if (control_ff[urf_pkg::CT_TX_INT_EN]) begin
                        irq_in = 1'b1;
                     end
                  end
               end
               urf_pkg::ADDR_CONTROL: begin
                  control_in  = req_port.write_data;
                  tx_ready_in = req_port.write_data[urf_pkg::CT_TX_EN];
               end
               default: begin
                  result.bus_error = 1'b1;
               end
            endcase
         end
         urf_pkg::OP_RX: begin
            if (control_ff[urf_pkg::CT_RX_EN]) begin
               if (fill < FILL_WIDTH'(FIFO_DEPTH)) begin
                  push_hit         = 1'b1;
                  result.rx_stored = 1'b1;
               end
               // A full FIFO drops the byte but still counts as holding data.
               rx_avail_in = 1'b1;
               if (control_ff[urf_pkg::CT_RX_INT_EN]) begin
                  irq_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      fill_after = fill;
      if (push_hit) begin
         fill_after = fill + FILL_WIDTH'(1);
      end else if (pop_hit) begin
         fill_after = fill - FILL_WIDTH'(1);
      end
      free_entries = FILL_WIDTH'(FIFO_DEPTH) - fill_after;

      if (control_in[urf_pkg::CT_RX_EN]) begin
         result.rx_space = urf_pkg::SPACE_WIDTH'(free_entries);
      end
      result.irq_level = irq_in;

      fifo_ctrl.push = accept && push_hit;
      fifo_ctrl.pop  = accept && pop_hit;
   end

   always_comb begin
      count_in = count_ff;
      if (accept && !rsp_take) begin
         count_in = count_ff + 2'd1;
      end else if (rsp_take && !accept) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff  <= '0;
         tx_ready_ff <= 1'b1;
         rx_avail_ff <= 1'b0;
         irq_ff      <= 1'b0;
         count_ff    <= 2'd0;
      end else begin
         if (accept) begin
            control_ff  <= control_in;
            tx_ready_ff <= tx_ready_in;
            rx_avail_ff <= rx_avail_in;
            irq_ff      <= irq_in;
         end
         count_ff <= count_in;
      end
   end

   // A take together with a new request only happens with one entry held.
   always_ff @(posedge clock) begin
      if (rsp_take) begin
         slot0_ff <= accept ? result : slot1_ff;
      end else if (accept) begin
         if (count_ff == 2'd0) begin
            slot0_ff <= result;
         end else begin
            slot1_ff <= result;
         end
      end
   end

   assign rsp_port.valid     = (count_ff != 2'd0);
   assign rsp_port.read_data = slot0_ff.read_data;
   assign rsp_port.tx_valid  = slot0_ff.tx_valid;
   assign rsp_port.tx_byte   = slot0_ff.tx_byte;
   assign rsp_port.irq_level = slot0_ff.irq_level;
   assign rsp_port.rx_stored = slot0_ff.rx_stored;
   assign rsp_port.rx_space  = slot0_ff.rx_space;
   assign rsp_port.bus_error = slot0_ff.bus_error;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) irq_ff |=> irq_ff)
      else $error("interrupt line fell without reset");

   assert property (@(posedge clock) disable iff (reset) fill <= FILL_WIDTH'(FIFO_DEPTH))
      else $error("receive FIFO fill beyond its depth");

   assert property (@(posedge clock) disable iff (reset)
      fifo_ctrl.pop |=> fill == $past(fill) - FILL_WIDTH'(1))
      else $error("DATA read did not remove one FIFO entry");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !accept) |=> count_ff == $past(count_ff) - 2'd1)
      else $error("response buffer count wrong after a take");

   assert property (@(posedge clock) disable iff (reset)
      (rx_avail_ff && !fifo_ctrl.pop) |-> fill != '0)
      else $error("RX available flag set with an empty FIFO");
`endif

endmodule

// ===== tb/sv/uart_register_checker.sv =====
// Checker that predicts the UART register block's responses and compares them field by field.
`timescale 1ns / 1ps

module uart_register_checker (
   input  logic clock,
   input  logic reset,
   urf_req_if   req_mon,
   urf_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   awaited_count
);

   localparam int DEPTH = urf_pkg::FIFO_DEPTH_DEFAULT;

   logic [7:0]       rx_cells [DEPTH];
   int               rx_fill;
   int               rx_head;
   logic [31:0]      control_word;
   logic             tx_ready;
   logic             rx_avail;
   logic             irq_held;
   urf_pkg::rsp_type expected_responses [$];

   // Applies one request to the modelled registers and FIFO and returns its response.
   function automatic urf_pkg::rsp_type next_uart_response(logic [1:0] op, logic [7:0] addr,
                                                           logic [31:0] wdata,
                                                           logic [7:0] line_byte);
      urf_pkg::rsp_type r;
      int               space_left;
      r = '0;
      case (op)
         urf_pkg::OP_READ: begin
            if (addr == urf_pkg::ADDR_DATA) begin
               if (rx_fill > 0) begin
                  r.read_data = {24'd0, rx_cells[rx_head]};
                  rx_head = (rx_head + 1) % DEPTH;
                  rx_fill--;
                  if (rx_fill == 0) rx_avail = 1'b0;
               end
            end else if (addr == urf_pkg::ADDR_STATUS) begin
               r.read_data[urf_pkg::ST_TX_READY] = tx_ready;
               r.read_data[urf_pkg::ST_RX_AVAIL] = rx_avail;
            end else if (addr == urf_pkg::ADDR_CONTROL) begin
               r.read_data = control_word;
            end else begin
               r.bus_error = 1'b1;
            end
         end
         urf_pkg::OP_WRITE: begin
            if (addr == urf_pkg::ADDR_DATA) begin
               if (control_word[urf_pkg::CT_TX_EN]) begin
                  r.tx_valid = 1'b1;
                  r.tx_byte = wdata[7:0];
                  tx_ready = 1'b1;
                  if (control_word[urf_pkg::CT_TX_INT_EN]) irq_held = 1'b1;
               end
            end else if (addr == urf_pkg::ADDR_CONTROL) begin
               control_word = wdata;
               tx_ready = wdata[urf_pkg::CT_TX_EN];
            end else begin
               r.bus_error = 1'b1;
            end
         end
         urf_pkg::OP_RX: begin
            if (control_word[urf_pkg::CT_RX_EN]) begin
               if (rx_fill < DEPTH) begin
                  rx_cells[(rx_head + rx_fill) % DEPTH] = line_byte;
                  rx_fill++;
                  r.rx_stored = 1'b1;
               end
               // A full FIFO still flags data available and may raise the interrupt.
               if (rx_fill > 0) begin
                  rx_avail = 1'b1;
                  if (control_word[urf_pkg::CT_RX_INT_EN]) irq_held = 1'b1;
               end
            end
         end
         default: ;
      endcase
      space_left = control_word[urf_pkg::CT_RX_EN] ? DEPTH - rx_fill : 0;
      r.irq_level = irq_held;
      r.rx_space = space_left[urf_pkg::SPACE_WIDTH-1:0];
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] expected,
                                input logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0h, got %0h", field, expected, actual);
         mismatch_count++;
      end
   endtask

   initial begin
      mismatch_count = 0;
      awaited_count = 0;
   end

   // Sampling on the falling edge sees settled handshakes for the coming rising edge.
   always @(negedge clock) begin : watch
      urf_pkg::rsp_type wanted;
      if (reset) begin
         rx_fill = 0;
         rx_head = 0;
         control_word = '0;
         tx_ready = 1'b1;
         rx_avail = 1'b0;
         irq_held = 1'b0;
         expected_responses.delete();
      end else begin
         // Responses are checked first so that a request taken at the same edge is not matched.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_responses.size() == 0) begin
               $error("response arrived with no request outstanding");
               mismatch_count++;
            end else begin
               wanted = expected_responses.pop_front();
               compare_field("read_data", wanted.read_data, rsp_mon.read_data);
               compare_field("tx_valid", 32'(wanted.tx_valid), 32'(rsp_mon.tx_valid));
               compare_field("tx_byte", 32'(wanted.tx_byte), 32'(rsp_mon.tx_byte));
               compare_field("irq_level", 32'(wanted.irq_level), 32'(rsp_mon.irq_level));
               compare_field("rx_stored", 32'(wanted.rx_stored), 32'(rsp_mon.rx_stored));
               compare_field("rx_space", 32'(wanted.rx_space), 32'(rsp_mon.rx_space));
               compare_field("bus_error", 32'(wanted.bus_error), 32'(rsp_mon.bus_error));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_responses.push_back(next_uart_response(req_mon.operation,
               req_mon.address, req_mon.write_data, req_mon.rx_byte));
      end
      awaited_count = expected_responses.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the UART register block testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 600;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_kind_type;

   logic           clock = 1'b0;
   logic           reset;
   int             mismatch_count;
   int             awaited_count;
   int             burst_left = 0;
   stall_kind_type stall_kind = STALL_NONE;
   int             stall_left = 0;
   int             stall_tick = 0;

   urf_req_if req_bus ();
   urf_rsp_if rsp_bus ();

   uart_registers_rx_fifo uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   uart_register_checker register_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   always #5 clock = ~clock;

   // The response side switches between stretches of no stalls, random stalls and a fixed rhythm.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind <= stall_kind_type'($urandom_range(0, 2));
         stall_left <= $urandom_range(8, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_tick <= stall_tick + 1;
      case (stall_kind)
         STALL_NONE:   rsp_bus.ready <= 1'b1;
         STALL_RANDOM: rsp_bus.ready <= ($urandom_range(0, 2) != 0);
         default:      rsp_bus.ready <= (stall_tick % 9) < 5;
      endcase
   end

   // Presents one request and returns at the rising edge that accepts it.
   task automatic send_request(input logic [1:0] op, input logic [7:0] addr,
                               input logic [31:0] wdata, input logic [7:0] line_byte);
      bit taken;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.address <= addr;
      req_bus.write_data <= wdata;
      req_bus.rx_byte <= line_byte;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      burst_left--;
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      logic [1:0]  op;
      logic [7:0]  addr;
      logic [31:0] wdata;
      int          pick;
      int          rx_share;
      bit          filling;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.operation <= urf_pkg::OP_READ;
      req_bus.address <= urf_pkg::ADDR_DATA;
      req_bus.write_data <= '0;
      req_bus.rx_byte <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset values, error offsets and everything ignored while the UART is disabled.
      send_request(urf_pkg::OP_READ, urf_pkg::ADDR_STATUS, '0, '0);
      send_request(urf_pkg::OP_READ, urf_pkg::ADDR_CONTROL, '0, '0);
      send_request(urf_pkg::OP_READ, urf_pkg::ADDR_DATA, '0, '0);
      send_request(urf_pkg::OP_WRITE, urf_pkg::ADDR_DATA, 32'h0000_00A5, '0);
      send_request(urf_pkg::OP_WRITE, urf_pkg::ADDR_STATUS, 32'hFFFF_FFFF, '0);
      send_request(urf_pkg::OP_READ, 8'hFF, '0, '0);
      send_request(urf_pkg::OP_WRITE, 8'h01, 32'h1234_5678, '0);
      send_request(urf_pkg::OP_RX, urf_pkg::ADDR_DATA, '0, 8'h5A);
      send_request(OP_SPARE, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
      // Enable both directions without interrupts, send one byte, then fill the FIFO past its depth.
      send_request(urf_pkg::OP_WRITE, urf_pkg::ADDR_CONTROL, 32'h0000_0003, '0);
      send_request(urf_pkg::OP_WRITE, urf_pkg::ADDR_DATA, 32'hFFFF_FFFF, '0);
      for (int i = 0; i <= urf_pkg::FIFO_DEPTH_DEFAULT; i++)
         send_request(urf_pkg::OP_RX, urf_pkg::ADDR_DATA, '0,
                      (i == 0) ? 8'h00 :
                      (i == urf_pkg::FIFO_DEPTH_DEFAULT - 1) ? 8'hFF : 8'($urandom));
      // A data read still pops with receive disabled.
      send_request(urf_pkg::OP_WRITE, urf_pkg::ADDR_CONTROL, 32'h0000_0000, '0);
      send_request(urf_pkg::OP_READ, urf_pkg::ADDR_DATA, '0, '0);
      send_request(urf_pkg::OP_WRITE, urf_pkg::ADDR_CONTROL, 32'hFFFF_FFFF, '0);

      // Alternating phases lean towards filling or draining the FIFO.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) filling = $urandom_range(0, 1);
         rx_share = filling ? 45 : 15;
         pick = $urandom_range(0, 99);
         addr = 8'($urandom);
         wdata = $urandom;
         if (pick < rx_share) begin
            op = urf_pkg::OP_RX;
         end else if (pick < rx_share + (filling ? 25 : 50)) begin
            op = urf_pkg::OP_READ;
            pick = $urandom_range(0, 99);
            if (pick < 70) addr = urf_pkg::ADDR_DATA;
            else if (pick < 82) addr = urf_pkg::ADDR_STATUS;
            else if (pick < 92) addr = urf_pkg::ADDR_CONTROL;
         end else if (pick < 95) begin
            op = urf_pkg::OP_WRITE;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               addr = urf_pkg::ADDR_DATA;
            end else if (pick < 80) begin
               addr = urf_pkg::ADDR_CONTROL;
               wdata[urf_pkg::CT_RX_EN] = ($urandom_range(0, 4) != 0);
               wdata[urf_pkg::CT_TX_EN] = ($urandom_range(0, 3) != 0);
            end else if (pick < 85) begin
               addr = urf_pkg::ADDR_STATUS;
            end
         end else begin
            op = OP_SPARE;
         end
         send_request(op, addr, wdata, 8'($urandom));
      end

      req_bus.valid <= 1'b0;
      wait (awaited_count == 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
design/urf_pkg.sv
design/urf_if.sv
design/urf_cell.sv
design/urf_fifo.sv
design/uart_registers_rx_fifo.sv
tb/sv/uart_register_checker.sv
tb/sv/testbench.sv
